// ===== rtl/lzno_pkg.sv =====
// Package: types, constants and quarter-wave trig tables for the lidar zone finder.
`timescale 1ns / 1ps

package lzno_pkg;

   localparam int ANGLE_BITS       = 16;
   localparam int TRIG_TABLE_DEPTH = 1024;
   localparam int IDX_BITS         = $clog2(TRIG_TABLE_DEPTH);
   localparam int QUARTER_DEPTH    = TRIG_TABLE_DEPTH / 4;
   localparam int QIDX_BITS        = IDX_BITS - 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] EMPTY_MM = 16'd10000;

   localparam logic [2:0] REG_START_ANGLE = 3'd0;
   localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
   localparam logic [2:0] REG_BOX_X_LOW   = 3'd2;
   localparam logic [2:0] REG_BOX_X_HIGH  = 3'd3;
   localparam logic [2:0] REG_BOX_Y_LOW   = 3'd4;
   localparam logic [2:0] REG_BOX_Y_HIGH  = 3'd5;
   localparam logic [2:0] REG_NEAR_BOTH   = 3'd6;
   localparam logic [2:0] REG_SIDE_LIMIT  = 3'd7;

   localparam logic [1:0] CLASS_CLEAR = 2'd0;
   localparam logic [1:0] CLASS_BOTH  = 2'd1;
   localparam logic [1:0] CLASS_LEFT  = 2'd2;
   localparam logic [1:0] CLASS_RIGHT = 2'd3;

   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [14:0] ONE_Q14     = 15'd16384;

   localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210};
   localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                           64'd90, 64'd132, 64'd182};

   typedef logic [14:0] quarter_table_type [QUARTER_DEPTH];

   typedef struct packed {
      logic        [15:0] start_angle;
      logic        [15:0] angle_step;
      logic signed [15:0] box_x_low;
      logic signed [15:0] box_x_high;
      logic signed [15:0] box_y_low;
      logic        [14:0] box_y_high;
      logic        [15:0] near_both_limit;
      logic        [15:0] side_limit;
   } cfg_type;

   typedef struct packed {
      logic        [15:0] range_mm;
      logic               scan_end;
      logic signed [15:0] cos_q14;
      logic signed [15:0] sin_q14;
   } item_type;

   typedef struct packed {
      logic [15:0] left_min_mm;
      logic [15:0] right_min_mm;
      logic [1:0]  obstacle_class;
   } result_type;

   function automatic logic [14:0] series_entry(input int j, input bit even);
      logic [63:0] a;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] q;
      a    = HALF_PI_Q30 * 64'(4 * j) / TRIG_TABLE_DEPTH;
      term = even ? ONE_Q30 : a;
      sum  = signed'(term);
      for (int k = 0; k < 7; k++) begin
         term = (((term * a) >> 30) * a) >> 30;
         term = even ? term / COS_DIV[k] : term / SIN_DIV[k];
         if (k % 2 == 1) begin
            sum = sum + signed'(term);
         end else begin
            sum = sum - signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = (64'(sum) + 64'd32768) >> 16;
      if (q > 64'(ONE_Q14)) begin
         q = 64'(ONE_Q14);
      end
      return q[14:0];
   endfunction

   function automatic quarter_table_type build_quarter(input bit even);
      quarter_table_type t;
      for (int j = 0; j < QUARTER_DEPTH; j++) begin
         t[j] = series_entry(j, even);
      end
      return t;
   endfunction

   localparam quarter_table_type SIN_QUARTER = build_quarter(1'b0);
   localparam quarter_table_type COS_QUARTER = build_quarter(1'b1);

   function automatic logic signed [15:0] trig_lookup(input logic [ANGLE_BITS-1:0] angle);
      logic [ANGLE_BITS+IDX_BITS-1:0] scaled;
      logic [IDX_BITS-1:0]            idx;
      logic [1:0]                     quad;
      logic [14:0]                    mag;
      scaled = {angle, {IDX_BITS{1'b0}}};
      idx    = scaled[ANGLE_BITS +: IDX_BITS];
      quad   = idx[IDX_BITS-1 -: 2];
      mag    = quad[0] ? COS_QUARTER[idx[QIDX_BITS-1:0]] : SIN_QUARTER[idx[QIDX_BITS-1:0]];
      return quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
   endfunction

endpackage

// ===== rtl/lzno_front.sv =====
// Front end: steps the sample angle and looks up cosine and sine for each item.
`timescale 1ns / 1ps

module lzno_front (
   input  logic                clock,
   input  logic                reset,
   input  lzno_pkg::cfg_type   cfg,
   input  logic                req_push,
   input  logic [15:0]         req_range_mm,
   input  logic                req_scan_end,
   output logic                req_full,
   output logic                q_push,
   output lzno_pkg::item_type  q_item,
   input  logic                q_full
);

   logic [lzno_pkg::ANGLE_BITS-1:0] offset_ff;
   logic [lzno_pkg::ANGLE_BITS-1:0] offset_in;
   logic [lzno_pkg::ANGLE_BITS-1:0] angle;
   logic [lzno_pkg::ANGLE_BITS-1:0] cos_angle;

   assign req_full  = q_full;
   assign q_push    = req_push && !q_full;
   assign angle     = cfg.start_angle[lzno_pkg::ANGLE_BITS-1:0] + offset_ff;
   assign cos_angle = angle + lzno_pkg::ANGLE_BITS'(1 << (lzno_pkg::ANGLE_BITS - 2));

   always_comb begin
      q_item.range_mm = req_range_mm;
      q_item.scan_end = req_scan_end;
      q_item.cos_q14  = lzno_pkg::trig_lookup(cos_angle);
      q_item.sin_q14  = lzno_pkg::trig_lookup(angle);
   end

   always_comb begin
      offset_in = offset_ff;
      if (q_push) begin
         offset_in = req_scan_end ? '0 : offset_ff + cfg.angle_step[lzno_pkg::ANGLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

// ===== rtl/lzno_queue.sv =====
// Short queue of looked-up items between front and back end.
`timescale 1ns / 1ps

module lzno_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lzno_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output lzno_pkg::item_type  pop_item,
   output logic                empty
);

   lzno_pkg::item_type                entry_ff [lzno_pkg::QUEUE_DEPTH];
   logic [lzno_pkg::QPTR_BITS-1:0]    wr_ptr_ff;
   logic [lzno_pkg::QPTR_BITS-1:0]    rd_ptr_ff;
   logic [lzno_pkg::QPTR_BITS:0]      count_ff;
   logic [lzno_pkg::QPTR_BITS:0]      count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full     = count_ff == (lzno_pkg::QPTR_BITS+1)'(lzno_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/lzno_back.sv =====
// Back end: projects points, tests the box, keeps zone minimums and queues results.
`timescale 1ns / 1ps

module lzno_back (
   input  logic                clock,
   input  logic                reset,
   input  lzno_pkg::cfg_type   cfg,
   input  logic                q_empty,
   input  lzno_pkg::item_type  q_item,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [15:0]         rsp_left_min_mm,
   output logic [15:0]         rsp_right_min_mm,
   output logic [1:0]          rsp_obstacle_class
);

   logic                 advance;

   logic                 b1_valid_ff;
   logic [15:0]          b1_range_ff;
   logic                 b1_last_ff;
   logic signed [31:0]   b1_xq_ff;
   logic signed [31:0]   b1_yq_ff;
   logic signed [32:0]   xq_full;
   logic signed [32:0]   yq_full;

   logic                 b2_valid_ff;
   logic [15:0]          b2_range_ff;
   logic                 b2_last_ff;
   logic                 b2_left_ff;
   logic                 b2_right_ff;
   logic signed [31:0]   x_lo_q;
   logic signed [31:0]   x_hi_q;
   logic signed [31:0]   y_lo_q;
   logic signed [31:0]   y_hi_q;
   logic                 in_x;
   logic                 in_left;
   logic                 in_right;

   logic                 left_seen_ff;
   logic                 right_seen_ff;
   logic [15:0]          left_min_ff;
   logic [15:0]          right_min_ff;
   logic                 left_seen_nx;
   logic                 right_seen_nx;
   logic [15:0]          left_min_nx;
   logic [15:0]          right_min_nx;

   logic                 res_valid_ff;
   logic [15:0]          res_left_ff;
   logic [15:0]          res_right_ff;
   logic [1:0]           res_class;

   lzno_pkg::result_type                out_ff [lzno_pkg::QUEUE_DEPTH];
   logic [lzno_pkg::QPTR_BITS-1:0]      out_wr_ff;
   logic [lzno_pkg::QPTR_BITS-1:0]      out_rd_ff;
   logic [lzno_pkg::QPTR_BITS:0]        out_count_ff;
   logic                                out_full;
   logic                                out_push;
   logic                                out_pop;
   lzno_pkg::result_type                out_item;

   assign out_full = out_count_ff == (lzno_pkg::QPTR_BITS+1)'(lzno_pkg::QUEUE_DEPTH);
   assign advance  = !(res_valid_ff && out_full);
   assign q_pop    = advance && !q_empty;

   // project
   assign xq_full = signed'({1'b0, q_item.range_mm}) * q_item.cos_q14;
   assign yq_full = signed'({1'b0, q_item.range_mm}) * q_item.sin_q14;

   // box test
   assign x_lo_q   = {{2{cfg.box_x_low[15]}}, cfg.box_x_low, 14'b0};
   assign x_hi_q   = {{2{cfg.box_x_high[15]}}, cfg.box_x_high, 14'b0};
   assign y_lo_q   = {{2{cfg.box_y_low[15]}}, cfg.box_y_low, 14'b0};
   assign y_hi_q   = {3'b0, cfg.box_y_high, 14'b0};
   assign in_x     = (b1_range_ff != '0) && (b1_xq_ff >= x_lo_q) && (b1_xq_ff <= x_hi_q);
   assign in_left  = in_x && (b1_yq_ff >= y_lo_q) && (b1_yq_ff < 0);
   assign in_right = in_x && (b1_yq_ff >= 0) && (b1_yq_ff <= y_hi_q);

   // running minimums
   always_comb begin
      left_seen_nx  = left_seen_ff | b2_left_ff;
      right_seen_nx = right_seen_ff | b2_right_ff;
      left_min_nx   = left_min_ff;
      right_min_nx  = right_min_ff;
      if (b2_left_ff && (!left_seen_ff || b2_range_ff < left_min_ff)) begin
         left_min_nx = b2_range_ff;
      end
      if (b2_right_ff && (!right_seen_ff || b2_range_ff < right_min_ff)) begin
         right_min_nx = b2_range_ff;
      end
   end

   always_comb begin
      if (res_left_ff < cfg.near_both_limit && res_right_ff < cfg.near_both_limit) begin
         res_class = lzno_pkg::CLASS_BOTH;
      end else if (res_left_ff < cfg.side_limit) begin
         res_class = lzno_pkg::CLASS_LEFT;
      end else if (res_right_ff < cfg.side_limit) begin
         res_class = lzno_pkg::CLASS_RIGHT;
      end else begin
         res_class = lzno_pkg::CLASS_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff   <= 1'b0;
         b2_valid_ff   <= 1'b0;
         res_valid_ff  <= 1'b0;
         left_seen_ff  <= 1'b0;
         right_seen_ff <= 1'b0;
         left_min_ff   <= lzno_pkg::EMPTY_MM;
         right_min_ff  <= lzno_pkg::EMPTY_MM;
      end else if (advance) begin
         b1_valid_ff  <= !q_empty;
         b2_valid_ff  <= b1_valid_ff;
         res_valid_ff <= b2_valid_ff && b2_last_ff;
         if (b2_valid_ff) begin
            if (b2_last_ff) begin
               left_seen_ff  <= 1'b0;
               right_seen_ff <= 1'b0;
               left_min_ff   <= lzno_pkg::EMPTY_MM;
               right_min_ff  <= lzno_pkg::EMPTY_MM;
            end else begin
               left_seen_ff  <= left_seen_nx;
               right_seen_ff <= right_seen_nx;
               left_min_ff   <= left_min_nx;
               right_min_ff  <= right_min_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_range_ff  <= q_item.range_mm;
         b1_last_ff   <= q_item.scan_end;
         b1_xq_ff     <= xq_full[31:0];
         b1_yq_ff     <= yq_full[31:0];
         b2_range_ff  <= b1_range_ff;
         b2_last_ff   <= b1_last_ff;
         b2_left_ff   <= in_left;
         b2_right_ff  <= in_right;
         res_left_ff  <= left_seen_nx ? left_min_nx : lzno_pkg::EMPTY_MM;
         res_right_ff <= right_seen_nx ? right_min_nx : lzno_pkg::EMPTY_MM;
      end
   end

   // result queue
   assign out_push  = res_valid_ff && !out_full;
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_empty = out_count_ff == '0;
   assign out_item  = out_ff[out_rd_ff];
   assign rsp_left_min_mm    = out_item.left_min_mm;
   assign rsp_right_min_mm   = out_item.right_min_mm;
   assign rsp_obstacle_class = out_item.obstacle_class;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         if (out_push) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
         if (out_push && !out_pop) begin
            out_count_ff <= out_count_ff + 1'b1;
         end else if (out_pop && !out_push) begin
            out_count_ff <= out_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ff] <= '{left_min_mm: res_left_ff, right_min_mm: res_right_ff,
                                obstacle_class: res_class};
      end
   end

endmodule

// ===== rtl/lidar_zone_nearest_obstacle.sv =====
// Top level: register file, front end, item queue and back end of the zone finder.
//
//   chan  handshake            payload                                            accept
//   req   req_push/req_full    req_range_mm req_scan_end                          push & !full
//   rsp   rsp_pop/rsp_empty    rsp_left_min_mm rsp_right_min_mm rsp_obstacle_class pop & !empty
//   csr   csr_valid/csr_ready  csr_index csr_data                                 valid & ready
//
// One item per cycle sustained while the back end is not stalled; angle lookup is combinational
// before the item queue; multiply, box test and minimum update each take one pipeline stage.
// A scan_end item's result passes through the b1, b2 and result registers into the result queue.
// Reset clears the queues, the pipeline and the scan state; registers take defaults.
// A full result queue stalls the back end once another result waits; the item queue then fills and raises req_full.
`timescale 1ns / 1ps

module lidar_zone_nearest_obstacle (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_range_mm,
   input  logic        req_scan_end,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [15:0] rsp_left_min_mm,
   output logic [15:0] rsp_right_min_mm,
   output logic [1:0]  rsp_obstacle_class,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   lzno_pkg::cfg_type  cfg_ff;
   logic               q_push;
   lzno_pkg::item_type q_push_item;
   logic               q_full;
   logic               q_pop;
   lzno_pkg::item_type q_pop_item;
   logic               q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_angle     <= '0;
         cfg_ff.angle_step      <= '0;
         cfg_ff.box_x_low       <= -16'sd450;
         cfg_ff.box_x_high      <= -16'sd30;
         cfg_ff.box_y_low       <= -16'sd400;
         cfg_ff.box_y_high      <= 15'd400;
         cfg_ff.near_both_limit <= '0;
         cfg_ff.side_limit      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lzno_pkg::REG_START_ANGLE: cfg_ff.start_angle     <= csr_data;
            lzno_pkg::REG_ANGLE_STEP:  cfg_ff.angle_step      <= csr_data;
            lzno_pkg::REG_BOX_X_LOW:   cfg_ff.box_x_low       <= csr_data;
            lzno_pkg::REG_BOX_X_HIGH:  cfg_ff.box_x_high      <= csr_data;
            lzno_pkg::REG_BOX_Y_LOW:   cfg_ff.box_y_low       <= csr_data;
            lzno_pkg::REG_BOX_Y_HIGH:  cfg_ff.box_y_high      <= csr_data[14:0];
            lzno_pkg::REG_NEAR_BOTH:   cfg_ff.near_both_limit <= csr_data;
            lzno_pkg::REG_SIDE_LIMIT:  cfg_ff.side_limit      <= csr_data;
            default: ;
         endcase
      end
   end

   lzno_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_range_mm (req_range_mm),
      .req_scan_end (req_scan_end),
      .req_full     (req_full),
      .q_push       (q_push),
      .q_item       (q_push_item),
      .q_full       (q_full)
   );

   lzno_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   lzno_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .q_item             (q_pop_item),
      .q_pop              (q_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_left_min_mm    (rsp_left_min_mm),
      .rsp_right_min_mm   (rsp_right_min_mm),
      .rsp_obstacle_class (rsp_obstacle_class)
   );

endmodule

// ===== rtl/lzno_checker.sv =====
// Port-level checker for the zone finder and its bind to the top level.
`timescale 1ns / 1ps

module lzno_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_pop,
   input logic        rsp_empty,
   input logic [15:0] rsp_left_min_mm,
   input logic [15:0] rsp_right_min_mm,
   input logic [1:0]  rsp_obstacle_class,
   input logic        csr_valid,
   input logic        csr_ready
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_full_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !(req_full && rsp_empty))
      else $error("input stalled with no result waiting");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_left_min_mm)
         && $stable(rsp_right_min_mm) && $stable(rsp_obstacle_class))
      else $error("waiting result changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind lidar_zone_nearest_obstacle lzno_checker u_lzno_checker (.*);
